// ===== src/owb_pkg.sv =====
// ----------------------------------------------------------------------------
// One-wire sender package
// Shared constants, types and helpers of the one-wire pulse-width byte sender.
// ----------------------------------------------------------------------------
package owb_pkg;

  // Frame and counter geometry.
  localparam int BITS_PER_FRAME = 8;
  localparam int COUNT_WIDTH    = 16;

  // Widths of the fixed interface fields.
  localparam int DATA_W = 8;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;

  localparam int BIT_IDX_W = (BITS_PER_FRAME > 1) ? $clog2(BITS_PER_FRAME) : 1;
  localparam int SHIFT_W   = (BITS_PER_FRAME > DATA_W) ? BITS_PER_FRAME : DATA_W;

  localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BITS_PER_FRAME - 1);

  // Register reset values.
  localparam logic [CFG_W-1:0] START_LOW_RST  = CFG_W'(3000);
  localparam logic [CFG_W-1:0] LONG_PHASE_RST = CFG_W'(600);
  localparam logic [CFG_W-1:0] SHORT_PHASE_RST = CFG_W'(200);

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] CFG_START_LOW   = IDX_W'(0);
  localparam logic [IDX_W-1:0] CFG_LONG_PHASE  = IDX_W'(1);
  localparam logic [IDX_W-1:0] CFG_SHORT_PHASE = IDX_W'(2);

  // Item kinds.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SEND = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_HIGH  = 2'd2,
    PH_LOW   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] start_low;
    logic [CFG_W-1:0] long_phase;
    logic [CFG_W-1:0] short_phase;
  } cfg_t;

  typedef struct packed {
    phase_t                 phase;
    logic [SHIFT_W-1:0]     shift;
    logic [BIT_IDX_W-1:0]   bit_idx;
    logic [COUNT_WIDTH-1:0] ticks_left;
    logic                   wire_out;
  } state_t;

  typedef struct packed {
    logic line_level;
    logic sending;
    logic byte_accepted;
    logic playing;
  } result_t;

  // A duration is cut to the counter width; zero counts as one tick.
  function automatic logic [COUNT_WIDTH-1:0] load_count(input logic [CFG_W-1:0] v);
    logic [COUNT_WIDTH-1:0] c;
    c = COUNT_WIDTH'(v);
    return (c == '0) ? COUNT_WIDTH'(1) : c;
  endfunction

endpackage

// ===== src/one_wire_pulse_width_byte_sender_core.sv =====
// ----------------------------------------------------------------------------
// One-wire pulse-width byte sender
// Drives a command byte onto a single high-idle wire as timed pulse widths.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                                         Moves
//  -------  --------------------------------------------  ----------------------
//  in       in_valid/in_ready, in_cmd, in_data_byte,      one tick or send item
//           in_chip_busy_pin
//  out      out_valid/out_ready, out_line_level,          one result item
//           out_sending, out_byte_accepted, out_playing
//  cfg      cfg_we, cfg_index, cfg_wdata                  one register write
//
// Throughput is one item per clock while the output is not stalled. An
// accepted item is held in the input register while the step logic works on
// it, and its result is then captured in the output register, which drives
// out_valid.
// Reset is synchronous and active low; it returns the durations to their
// defaults, idles the wire high and empties both registers.
// A stalled output holds its result, and the input register keeps taking an
// item while the output register drains, so the block only stops accepting
// when both registers are full and out_ready is low.
// ----------------------------------------------------------------------------
module one_wire_pulse_width_byte_sender_core (
  input  logic                       clk,
  input  logic                       rst_n,

  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_cmd,
  input  logic [owb_pkg::DATA_W-1:0] in_data_byte,
  input  logic                       in_chip_busy_pin,

  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_line_level,
  output logic                       out_sending,
  output logic                       out_byte_accepted,
  output logic                       out_playing,

  input  logic                       cfg_we,
  input  logic [owb_pkg::IDX_W-1:0]  cfg_index,
  input  logic [owb_pkg::CFG_W-1:0]  cfg_wdata
);

  owb_pkg::cfg_t    cfg;
  owb_pkg::state_t  state_r;
  owb_pkg::state_t  state_nxt;
  owb_pkg::result_t res_nxt;
  owb_pkg::result_t res_r;

  // Input register.
  logic                       in_v_r;
  logic                       in_cmd_r;
  logic [owb_pkg::DATA_W-1:0] in_data_r;
  logic                       in_busy_r;

  logic out_v_r;
  logic step_fire;

  owb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The buffered item advances whenever the output register is free or is
  // being emptied in this cycle.
  assign step_fire = in_v_r && (!out_v_r || out_ready);
  assign in_ready  = !in_v_r || step_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_cmd_r  <= in_cmd;
      in_data_r <= in_data_byte;
      in_busy_r <= in_chip_busy_pin;
    end
  end

  owb_step u_step (
    .cfg           (cfg),
    .state         (state_r),
    .cmd           (in_cmd_r),
    .data_byte     (in_data_r),
    .chip_busy_pin (in_busy_r),
    .state_nxt     (state_nxt),
    .res           (res_nxt)
  );

  // Transmitter state only moves when an item passes through the step logic.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase      <= owb_pkg::PH_IDLE;
      state_r.shift      <= '0;
      state_r.bit_idx    <= '0;
      state_r.ticks_left <= '0;
      state_r.wire_out   <= 1'b1;
    end else if (step_fire) begin
      state_r <= state_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step_fire) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_v_r;
  assign out_line_level    = res_r.line_level;
  assign out_sending       = res_r.sending;
  assign out_byte_accepted = res_r.byte_accepted;
  assign out_playing       = res_r.playing;

`ifndef SYNTHESIS
  // The wire is never left low while no transmission runs.
  a_idle_line_high: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == owb_pkg::PH_IDLE) |-> state_r.wire_out)
    else $error("line low while idle");

  // A running phase always has at least one tick left.
  a_ticks_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase != owb_pkg::PH_IDLE) |-> (state_r.ticks_left != '0))
    else $error("phase running with empty counter");

  // A started transmission opens with the line low.
  a_accept_starts_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && res_r.byte_accepted) |-> (!res_r.line_level && res_r.sending))
    else $error("accepted byte without start pulse");

  // No item is taken while both registers are full and the output stalls.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !(in_v_r && out_v_r && !out_ready))
    else $error("item accepted into a full pipeline");
`endif

endmodule

// ===== src/owb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// One-wire sender configuration registers
// Holds the three phase durations written through the plain write port.
// ----------------------------------------------------------------------------
module owb_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [owb_pkg::IDX_W-1:0] cfg_index,
  input  logic [owb_pkg::CFG_W-1:0] cfg_wdata,
  output owb_pkg::cfg_t             cfg
);

  owb_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_low   <= owb_pkg::START_LOW_RST;
      cfg_r.long_phase  <= owb_pkg::LONG_PHASE_RST;
      cfg_r.short_phase <= owb_pkg::SHORT_PHASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        owb_pkg::CFG_START_LOW:   cfg_r.start_low   <= cfg_wdata;
        owb_pkg::CFG_LONG_PHASE:  cfg_r.long_phase  <= cfg_wdata;
        owb_pkg::CFG_SHORT_PHASE: cfg_r.short_phase <= cfg_wdata;
        default: ;  // Unused index: write is ignored.
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/owb_step.sv =====
// ----------------------------------------------------------------------------
// One-wire sender step logic
// Next state of the transmitter and the result for one item.
// ----------------------------------------------------------------------------
module owb_step (
  input  owb_pkg::cfg_t              cfg,
  input  owb_pkg::state_t            state,
  input  logic                       cmd,
  input  logic [owb_pkg::DATA_W-1:0] data_byte,
  input  logic                       chip_busy_pin,
  output owb_pkg::state_t            state_nxt,
  output owb_pkg::result_t           res
);

  logic [owb_pkg::COUNT_WIDTH-1:0] dec;
  logic                            accepted;
  logic                            lsb;

  assign dec = state.ticks_left - owb_pkg::COUNT_WIDTH'(1);
  assign lsb = state.shift[0];

  always_comb begin
    state_nxt = state;
    accepted  = 1'b0;
    if (cmd == owb_pkg::CMD_SEND) begin
      if (state.phase == owb_pkg::PH_IDLE) begin
        state_nxt.shift      = owb_pkg::SHIFT_W'(data_byte);
        state_nxt.bit_idx    = '0;
        state_nxt.wire_out   = 1'b0;
        state_nxt.ticks_left = owb_pkg::load_count(cfg.start_low);
        state_nxt.phase      = owb_pkg::PH_START;
        accepted             = 1'b1;
      end
    end else if (state.phase != owb_pkg::PH_IDLE) begin
      state_nxt.ticks_left = dec;
      if (dec == '0) begin
        case (state.phase)
          owb_pkg::PH_START: begin
            state_nxt.wire_out   = 1'b1;
            state_nxt.ticks_left = owb_pkg::load_count(lsb ? cfg.long_phase
                                                           : cfg.short_phase);
            state_nxt.phase      = owb_pkg::PH_HIGH;
          end
          owb_pkg::PH_HIGH: begin
            state_nxt.wire_out   = 1'b0;
            state_nxt.ticks_left = owb_pkg::load_count(lsb ? cfg.short_phase
                                                           : cfg.long_phase);
            state_nxt.phase      = owb_pkg::PH_LOW;
          end
          owb_pkg::PH_LOW: begin
            if (state.bit_idx == owb_pkg::LAST_BIT) begin
              state_nxt.wire_out   = 1'b1;
              state_nxt.phase      = owb_pkg::PH_IDLE;
              state_nxt.ticks_left = '0;
              state_nxt.bit_idx    = '0;
              state_nxt.shift      = '0;
            end else begin
              state_nxt.bit_idx    = state.bit_idx + owb_pkg::BIT_IDX_W'(1);
              state_nxt.shift      = state.shift >> 1;
              state_nxt.wire_out   = 1'b1;
              state_nxt.ticks_left = owb_pkg::load_count(state.shift[1] ? cfg.long_phase
                                                                         : cfg.short_phase);
              state_nxt.phase      = owb_pkg::PH_HIGH;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign res.line_level    = state_nxt.wire_out;
  assign res.sending       = (state_nxt.phase != owb_pkg::PH_IDLE);
  assign res.byte_accepted = accepted;
  assign res.playing       = ~chip_busy_pin;

endmodule
